### hdl/csp_pkg.sv
// shared types, state codes and fixed-point helpers of the support point unit
package csp_pkg;

  typedef enum logic {
    KIND_PLANE   = 1'b0,
    KIND_ELLIPSE = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t         kind;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] vec_a_x;
    logic signed [31:0] vec_a_y;
    logic signed [31:0] vec_b_x;
    logic signed [31:0] vec_b_y;
    logic [30:0]        radius_x;
    logic [30:0]        radius_y;
    logic               last_element;
  } item_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] arg;
  } sqrt_req_t;

  typedef struct packed {
    logic               busy;
    logic signed [31:0] res;
  } unit_rsp_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_WAIT,
    ST_E1, ST_E2, ST_E3, ST_E4, ST_E5, ST_E6, ST_E7, ST_E8, ST_E9, ST_E10,
    ST_E11, ST_E12, ST_E13, ST_E14,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8, ST_P9,
    ST_P10, ST_P11, ST_P12, ST_P13, ST_P14, ST_P15, ST_P16, ST_P17, ST_P18,
    ST_P19, ST_P20, ST_P21, ST_P22, ST_P23, ST_P24, ST_P25, ST_P26, ST_P27,
    ST_P28, ST_P29, ST_P30, ST_P31, ST_P32, ST_P33, ST_P34, ST_P35,
    ST_W1, ST_W2, ST_W3, ST_W4, ST_W5, ST_W6, ST_W7, ST_W8
  } csp_state_t;

  function automatic logic signed [63:0] ext64(input logic signed [31:0] v);
    return 64'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

### hdl/csp_channels.sv
// valid/ready channel interfaces for input items and support points
interface csp_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] vec_a_x;
  logic signed [31:0] vec_a_y;
  logic signed [31:0] vec_b_x;
  logic signed [31:0] vec_b_y;
  logic [30:0]        radius_x;
  logic [30:0]        radius_y;
  logic               last_element;

  modport source (output valid, mode, dir_x, dir_y, vec_a_x, vec_a_y, vec_b_x, vec_b_y,
                  radius_x, radius_y, last_element, input ready);
  modport sink (input valid, mode, dir_x, dir_y, vec_a_x, vec_a_y, vec_b_x, vec_b_y,
                radius_x, radius_y, last_element, output ready);
endinterface

interface csp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] support_x;
  logic signed [31:0] support_y;

  modport source (output valid, support_x, support_y, input ready);
  modport sink (input valid, support_x, support_y, output ready);
endinterface

### hdl/csp_front.sv
// front end: takes input beats, tags their kind and queues them for the back end
module csp_front
  import csp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  csp_in_if.sink in_ch,
  output logic   q_valid,
  output item_t  q_item,
  input  logic   q_pop
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  item_t      tagged_item;

  assign in_ch.ready = (fill != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (fill != 2'd0);
  assign q_item      = slots[rd_ptr];

  always_comb begin
    tagged_item.kind         = in_ch.mode ? KIND_ELLIPSE : KIND_PLANE;
    tagged_item.dir_x        = in_ch.dir_x;
    tagged_item.dir_y        = in_ch.dir_y;
    tagged_item.vec_a_x      = in_ch.vec_a_x;
    tagged_item.vec_a_y      = in_ch.vec_a_y;
    tagged_item.vec_b_x      = in_ch.vec_b_x;
    tagged_item.vec_b_y      = in_ch.vec_b_y;
    tagged_item.radius_x     = in_ch.radius_x;
    tagged_item.radius_y     = in_ch.radius_y;
    tagged_item.last_element = in_ch.last_element;
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= tagged_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

### hdl/csp_div.sv
// shared radix-2 fixed-point divider, truncating toward zero, saturated
module csp_div
  import csp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  div_req_t  req,
  output unit_rsp_t rsp
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [NW-1:0]     num;
  logic [NW-1:0]     quo;
  logic [31:0]       dmag;
  logic [31:0]       rem;
  logic              neg;
  logic signed [31:0] res;
  logic signed [31:0] den_fix;
  logic [31:0]       amag;
  logic [32:0]       rem_sh;
  logic              ge;
  logic signed [63:0] q64;

  assign den_fix = (req.den == 32'sd0) ? ONE : req.den;
  assign amag    = req.num[31] ? (~req.num + 32'd1) : req.num;
  assign rem_sh  = {rem, num[NW-1]};
  assign ge      = (rem_sh >= {1'b0, dmag});
  assign q64     = neg ? -signed'(64'(quo)) : signed'(64'(quo));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
      num  <= {amag, {FRAC_BITS{1'b0}}};
      dmag <= den_fix[31] ? (~den_fix + 32'd1) : den_fix;
      neg  <= req.num[31] ^ den_fix[31];
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      if (cnt != '0) begin
        rem <= ge ? 32'(rem_sh - {1'b0, dmag}) : rem_sh[31:0];
        quo <= {quo[NW-2:0], ge};
        num <= num << 1;
        cnt <= cnt - CW'(1);
      end else begin
        res  <= sat32(q64);
        busy <= 1'b0;
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.res  = res;

endmodule

### hdl/csp_sqrt.sv
// shared digit-by-digit square root of a fixed-point value
module csp_sqrt
  import csp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  sqrt_req_t req,
  output unit_rsp_t rsp
);

  logic               busy;
  logic [63:0]        x;
  logic [63:0]        r;
  logic [63:0]        bt;
  logic signed [31:0] res;
  logic [63:0]        trial;

  assign trial = r + bt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      x    <= (!req.arg[31] && req.arg != 32'sd0) ? ({32'd0, req.arg} << FRAC_BITS) : 64'd0;
      r    <= '0;
      bt   <= 64'd1 << 62;
    end else if (busy) begin
      if (bt != 64'd0) begin
        if (x >= trial) begin
          x <= x - trial;
          r <= (r >> 1) + bt;
        end else begin
          r <= r >> 1;
        end
        bt <= bt >> 2;
      end else begin
        res  <= r[31:0];
        busy <= 1'b0;
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.res  = res;

endmodule

### hdl/csp_back.sv
// back end: sequencer over a shared multiplier, divider and square root
module csp_back
  import csp_pkg::*;
#(
  parameter int MAX_PLANES = 8,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  output div_req_t   dv_req,
  input  unit_rsp_t  dv_rsp,
  output sqrt_req_t  sq_req,
  input  unit_rsp_t  sq_rsp,
  csp_out_if.source  out_ch
);

  localparam int IW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int CW = $clog2(MAX_PLANES + 1);
  localparam logic signed [63:0] ONE64 = 64'sd1 <<< FRAC_BITS;

  csp_state_t state, state_next, ret;

  logic signed [31:0] po_x [MAX_PLANES];
  logic signed [31:0] po_y [MAX_PLANES];
  logic signed [31:0] pn_x [MAX_PLANES];
  logic signed [31:0] pn_y [MAX_PLANES];
  logic [CW-1:0]      pcount;
  logic [CW-1:0]      pi;

  item_t              cur;
  logic signed [31:0] rx, ry;
  logic signed [31:0] lx, ly, qx, qy, den, px, py;
  logic signed [31:0] ox, oy, nx, ny, ppx, ppy, vx, vy, plen, ux, uy, l, cx, cy;
  logic signed [31:0] l0, l1, t, t2, p0x, p0y, p1x, p1y, wx, wy;
  logic signed [63:0] acc, d0, sum, dot;
  logic signed [63:0] best_dot;
  logic signed [31:0] best_x, best_y;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod, mq;

  logic               out_valid;
  logic signed [31:0] out_x, out_y;

  assign rx  = {1'b0, cur.radius_x};
  assign ry  = {1'b0, cur.radius_y};
  assign mq  = prod >>> FRAC_BITS;
  assign sum = acc + mq;
  assign dot = acc + mq;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (q_valid && q_item.kind == KIND_ELLIPSE) state_next = ST_E1;
      ST_WAIT: if (!dv_rsp.busy && !sq_rsp.busy) state_next = ret;
      ST_E1:  state_next = ST_E2;
      ST_E2:  state_next = ST_E3;
      ST_E3:  state_next = ST_E4;
      ST_E4:  state_next = ST_E5;
      ST_E5:  state_next = ST_E6;
      ST_E6:  state_next = ST_E7;
      ST_E7:  state_next = ST_E8;
      ST_E8:  state_next = ST_E9;
      ST_E9:  state_next = ST_E10;
      ST_E10: state_next = ST_E11;
      ST_E11, ST_E12, ST_E13: state_next = ST_WAIT;
      ST_E14: state_next = ST_P0;
      ST_P0:  state_next = (pi == pcount) ? ST_W1 : ST_P1;
      ST_P1:  state_next = ST_P2;
      ST_P2:  state_next = ST_P3;
      ST_P3:  state_next = (sum > 64'sd0) ? ST_WAIT : ST_P0;
      ST_P4, ST_P5, ST_P6: state_next = ST_WAIT;
      ST_P7:  state_next = ST_P8;
      ST_P8:  state_next = ST_P9;
      ST_P9, ST_P10, ST_P11: state_next = ST_WAIT;
      ST_P12: state_next = ST_P13;
      ST_P13: state_next = ST_P14;
      ST_P14: state_next = ST_P15;
      ST_P15: state_next = ST_P16;
      ST_P16: state_next = ST_P17;
      ST_P17: state_next = ST_P18;
      ST_P18: state_next = ST_P19;
      ST_P19: state_next = ST_WAIT;
      ST_P20: state_next = ST_P21;
      ST_P21: state_next = ST_WAIT;
      ST_P22: state_next = ST_P23;
      ST_P23: state_next = ST_P24;
      ST_P24: state_next = ST_P25;
      ST_P25: state_next = ST_P26;
      ST_P26: state_next = ST_P27;
      ST_P27: state_next = ST_P28;
      ST_P28: state_next = ST_P29;
      ST_P29: state_next = ST_P30;
      ST_P30: state_next = ST_P31;
      ST_P31: state_next = ST_P32;
      ST_P32: state_next = ST_P33;
      ST_P33: state_next = ST_P34;
      ST_P34: state_next = ST_P35;
      ST_P35: state_next = ST_P0;
      ST_W1:  state_next = ST_W2;
      ST_W2:  state_next = ST_W3;
      ST_W3:  state_next = ST_W4;
      ST_W4:  state_next = ST_W5;
      ST_W5:  state_next = ST_W6;
      ST_W6:  state_next = ST_W7;
      ST_W7:  state_next = ST_W8;
      ST_W8:  if (!cur.last_element || !out_valid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // operand selection and unit starts
  always_comb begin
    q_pop  = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    dv_req = '0;
    sq_req = '0;
    unique case (state)
      ST_IDLE: q_pop = q_valid;
      ST_E1:  begin mul_a = cur.vec_b_x; mul_b = cur.dir_x; end
      ST_E2:  begin mul_a = cur.vec_b_y; mul_b = cur.dir_y; end
      ST_E3:  begin mul_a = cur.vec_b_x; mul_b = cur.dir_y; end
      ST_E4:  begin mul_a = cur.vec_b_y; mul_b = cur.dir_x; end
      ST_E5:  begin mul_a = rx; mul_b = rx; end
      ST_E6:  begin mul_a = sat32(mq); mul_b = lx; end
      ST_E7:  begin mul_a = ry; mul_b = ry; end
      ST_E8:  begin mul_a = sat32(mq); mul_b = ly; end
      ST_E9:  begin mul_a = qx; mul_b = lx; end
      ST_E10: begin mul_a = qy; mul_b = ly; end
      ST_E11: begin sq_req.start = 1'b1; sq_req.arg = sat32(sum); end
      ST_E12: begin dv_req.start = 1'b1; dv_req.num = qx; dv_req.den = sq_rsp.res; end
      ST_E13: begin dv_req.start = 1'b1; dv_req.num = qy; dv_req.den = den; end
      ST_P1:  begin mul_a = nx; mul_b = sat32(ext64(px) - ext64(ox)); end
      ST_P2:  begin mul_a = ny; mul_b = sat32(ext64(py) - ext64(oy)); end
      ST_P3:  begin dv_req.start = (sum > 64'sd0); dv_req.num = ox; dv_req.den = rx; end
      ST_P4:  begin dv_req.start = 1'b1; dv_req.num = oy; dv_req.den = ry; end
      ST_P5:  begin dv_req.start = 1'b1; dv_req.num = ny; dv_req.den = rx; end
      ST_P6:  begin dv_req.start = 1'b1; dv_req.num = sat32(-ext64(nx)); dv_req.den = ry; end
      ST_P7:  begin mul_a = vx; mul_b = vx; end
      ST_P8:  begin mul_a = dv_rsp.res; mul_b = dv_rsp.res; end
      ST_P9:  begin sq_req.start = 1'b1; sq_req.arg = sat32(sum); end
      ST_P10: begin dv_req.start = 1'b1; dv_req.num = vx; dv_req.den = sq_rsp.res; end
      ST_P11: begin dv_req.start = 1'b1; dv_req.num = vy; dv_req.den = plen; end
      ST_P12: begin mul_a = ux; mul_b = ppx; end
      ST_P13: begin mul_a = uy; mul_b = ppy; end
      ST_P15: begin mul_a = ux; mul_b = l; end
      ST_P16: begin mul_a = uy; mul_b = l; end
      ST_P17: begin mul_a = cx; mul_b = cx; end
      ST_P18: begin mul_a = cy; mul_b = cy; end
      ST_P19: begin sq_req.start = 1'b1; sq_req.arg = sat32(sum); end
      ST_P20: begin mul_a = sq_rsp.res; mul_b = sq_rsp.res; end
      ST_P21: begin sq_req.start = 1'b1; sq_req.arg = sat32(ONE64 - ext64(sat32(mq))); end
      ST_P23: begin mul_a = ux; mul_b = l0; end
      ST_P24: begin mul_a = uy; mul_b = l0; end
      ST_P25: begin mul_a = rx; mul_b = t; end
      ST_P26: begin mul_a = ry; mul_b = t2; end
      ST_P27: begin mul_a = ux; mul_b = l1; end
      ST_P28: begin mul_a = uy; mul_b = l1; end
      ST_P29: begin mul_a = rx; mul_b = t; end
      ST_P30: begin mul_a = ry; mul_b = t2; end
      ST_P31: begin mul_a = p0x; mul_b = lx; end
      ST_P32: begin mul_a = p0y; mul_b = ly; end
      ST_P33: begin mul_a = p1x; mul_b = lx; end
      ST_P34: begin mul_a = p1y; mul_b = ly; end
      ST_W1:  begin mul_a = cur.vec_b_x; mul_b = px; end
      ST_W2:  begin mul_a = cur.vec_b_y; mul_b = py; end
      ST_W3:  begin mul_a = cur.vec_b_y; mul_b = px; end
      ST_W4:  begin mul_a = cur.vec_b_x; mul_b = py; end
      ST_W5:  begin mul_a = wx; mul_b = cur.dir_x; end
      ST_W6:  begin mul_a = wy; mul_b = cur.dir_y; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // plane store and datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (q_valid && q_item.kind == KIND_PLANE && pcount < CW'(MAX_PLANES)) begin
          po_x[pcount[IW-1:0]] <= q_item.vec_a_x;
          po_y[pcount[IW-1:0]] <= q_item.vec_a_y;
          pn_x[pcount[IW-1:0]] <= q_item.vec_b_x;
          pn_y[pcount[IW-1:0]] <= q_item.vec_b_y;
        end
        if (q_valid) cur <= q_item;
      end
      ST_E2:  acc <= mq;
      ST_E3:  lx <= sat32(sum);
      ST_E4:  acc <= mq;
      ST_E5:  ly <= sat32(acc - mq);
      ST_E7:  qx <= sat32(mq);
      ST_E9:  qy <= sat32(mq);
      ST_E10: acc <= mq;
      ST_E12: den <= sq_rsp.res;
      ST_E13: px <= dv_rsp.res;
      ST_E14: py <= dv_rsp.res;
      ST_P0: begin
        ox <= po_x[pi[IW-1:0]];
        oy <= po_y[pi[IW-1:0]];
        nx <= pn_x[pi[IW-1:0]];
        ny <= pn_y[pi[IW-1:0]];
      end
      ST_P2:  acc <= mq;
      ST_P4:  ppx <= dv_rsp.res;
      ST_P5:  ppy <= dv_rsp.res;
      ST_P6:  vx <= dv_rsp.res;
      ST_P7:  vy <= dv_rsp.res;
      ST_P8:  acc <= mq;
      ST_P10: plen <= sq_rsp.res;
      ST_P11: ux <= dv_rsp.res;
      ST_P12: uy <= dv_rsp.res;
      ST_P13: acc <= mq;
      ST_P14: l <= sat32(-sum);
      ST_P16: cx <= sat32(ext64(ppx) + mq);
      ST_P17: cy <= sat32(ext64(ppy) + mq);
      ST_P18: acc <= mq;
      ST_P22: begin
        l0 <= sat32(ext64(l) - ext64(sq_rsp.res));
        l1 <= sat32(ext64(l) + ext64(sq_rsp.res));
      end
      ST_P24: t <= sat32(ext64(ppx) + mq);
      ST_P25: t2 <= sat32(ext64(ppy) + mq);
      ST_P26: p0x <= sat32(mq);
      ST_P27: p0y <= sat32(mq);
      ST_P28: t <= sat32(ext64(ppx) + mq);
      ST_P29: t2 <= sat32(ext64(ppy) + mq);
      ST_P30: p1x <= sat32(mq);
      ST_P31: p1y <= sat32(mq);
      ST_P32: acc <= mq;
      ST_P33: d0 <= sum;
      ST_P34: acc <= mq;
      ST_P35: begin
        // ties go to chord end p1, the l1 end
        if (d0 > sum) begin
          px <= p0x;
          py <= p0y;
        end else begin
          px <= p1x;
          py <= p1y;
        end
      end
      ST_W2:  acc <= mq;
      ST_W3:  t <= sat32(acc - mq);
      ST_W4: begin
        wx  <= sat32(ext64(cur.vec_a_x) + ext64(t));
        acc <= mq;
      end
      ST_W5:  wy <= sat32(ext64(cur.vec_a_y) + ext64(sat32(sum)));
      ST_W6:  acc <= mq;
      default: ;
    endcase
  end

  // control state: sequencer, plane count, running best and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret       <= ST_IDLE;
      pcount    <= '0;
      pi        <= '0;
      best_dot  <= {1'b1, 63'd0};
      best_x    <= '0;
      best_y    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid && q_item.kind == KIND_PLANE && pcount < CW'(MAX_PLANES))
            pcount <= pcount + CW'(1);
        end
        ST_E11: ret <= ST_E12;
        ST_E12: ret <= ST_E13;
        ST_E13: ret <= ST_E14;
        ST_E14: pi <= '0;
        ST_P3: begin
          ret <= ST_P4;
          if (!(sum > 64'sd0)) pi <= pi + CW'(1);
        end
        ST_P4:  ret <= ST_P5;
        ST_P5:  ret <= ST_P6;
        ST_P6:  ret <= ST_P7;
        ST_P9:  ret <= ST_P10;
        ST_P10: ret <= ST_P11;
        ST_P11: ret <= ST_P12;
        ST_P19: ret <= ST_P20;
        ST_P21: ret <= ST_P22;
        ST_P35: pi <= pi + CW'(1);
        ST_W7: begin
          pcount <= '0;
          if (dot > best_dot) begin
            best_dot <= dot;
            best_x   <= wx;
            best_y   <= wy;
          end
        end
        ST_W8: begin
          if (cur.last_element && !out_valid) begin
            out_valid <= 1'b1;
            out_x     <= best_x;
            out_y     <= best_y;
            best_dot  <= {1'b1, 63'd0};
            best_x    <= '0;
            best_y    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.support_x = out_x;
  assign out_ch.support_y = out_y;

endmodule

### hdl/clipped_ellipse_support_point_unit.sv
// top level of the clipped-ellipse support point unit
// Support point of a union of half-plane-clipped ellipses in Q(FRAC_BITS) fixed
// point. Plane beats are queued and stored (up to MAX_PLANES, extras dropped) for
// the next ellipse beat; an ellipse beat finds its local extreme point, snaps it
// to the better chord end for every violated plane, moves it to world space and
// keeps the running best; an ellipse marked last emits one support point beat.
// A two-entry queue parts the input from the sequencer, and the result sits in an
// output register, so input is taken while a result waits. A plane beat is stored
// straight from the idle state. An ellipse's time is set by the shared iterative
// divider and square root, and grows with every stored plane, most of all with
// every violated plane; one ellipse is worked at a time, and a last ellipse waits
// at the end while the previous point is still untaken.
module clipped_ellipse_support_point_unit
  import csp_pkg::*;
#(
  parameter int MAX_PLANES = 8,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  csp_in_if.sink     in_ch,
  csp_out_if.source  out_ch
);

  // queue between front and back
  logic      q_valid;
  item_t     q_item;
  logic      q_pop;

  // shared arithmetic units
  div_req_t  dv_req;
  unit_rsp_t dv_rsp;
  sqrt_req_t sq_req;
  unit_rsp_t sq_rsp;

  csp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  csp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .rst (rst),
    .req (dv_req),
    .rsp (dv_rsp)
  );

  csp_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sq_req),
    .rsp (sq_rsp)
  );

  // sequencer owns the plane store, the running best and the result register
  csp_back #(.MAX_PLANES(MAX_PLANES), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .dv_req  (dv_req),
    .dv_rsp  (dv_rsp),
    .sq_req  (sq_req),
    .sq_rsp  (sq_rsp),
    .out_ch  (out_ch)
  );

endmodule
